>>> hdl/rfd_pkg.sv
// Package for the reply frame deframer: framing characters, result kinds,
// register indexes and the phase type. No dependencies.
package rfd_pkg;

    localparam logic [7:0] CH_START    = 8'h3C;
    localparam logic [7:0] CH_SEP      = 8'h24;
    localparam logic [7:0] CH_END      = 8'h3E;
    localparam logic [7:0] CH_ESC      = 8'h2F;
    localparam logic [7:0] CH_KEYREPLY = 8'h4F;
    localparam logic [7:0] CH_DATA_LO  = 8'h30;
    localparam logic [7:0] CH_DATA_HI  = 8'h34;
    localparam logic [7:0] CH_KEY_LO   = 8'h41;
    localparam logic [7:0] CH_KEY_HI   = 8'h45;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] TYPE_OFFSET = 8'd5;

    localparam logic [7:0] REQ_TYPE_RESET   = 8'h30;
    localparam logic [6:0] MAX_LENGTH_RESET = 7'd80;
    localparam logic [3:0] HEADER_BYTES     = 4'd4;

    localparam int CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_REQUESTED_TYPE = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_LENGTH     = 8'd1;

    typedef enum logic [2:0] {
        K_NONE     = 3'd0,
        K_DATA     = 3'd1,
        K_DONE     = 3'd2,
        K_MISMATCH = 3'd3,
        K_KEY      = 3'd4,
        K_CORRUPT  = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN1,
        PH_LEN2,
        PH_SEP1,
        PH_TYPE,
        PH_SEP2,
        PH_PAYLOAD
    } t_phase;

endpackage

>>> hdl/reply_frame_deframer_core.sv
// Reply frame deframer: header parsing, type check and payload un-stuffing.
// Depends on rfd_pkg for characters, kinds, register indexes and phases.
//
// Channel   Direction  Signals
// input     in         i_in_valid, o_in_ready, i_rx_byte
// result    out        o_out_valid, i_out_ready, o_kind, o_data_byte
// config    in         i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data
//
// Every accepted byte gives one result, held in the result register.
// The result register alone sets the rate: one byte per cycle unless its result waits.
// A new byte is taken while the held result is transferred in the same cycle.
// Reset is synchronous and active low; it restores the register defaults.
module reply_frame_deframer_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [7:0]                     i_rx_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [2:0]                     o_kind,
    output logic [7:0]                     o_data_byte,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rfd_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data
);

    rfd_pkg::t_phase    r_phase, n_phase;
    logic signed [8:0]  r_first, n_first;
    logic signed [12:0] r_decl, n_decl;
    logic [7:0]         r_rtype, n_rtype;
    logic [6:0]         r_scanned, n_scanned;
    logic               r_escape, n_escape;
    logic [7:0]         r_req_type;
    logic [6:0]         r_max_len;
    logic               r_out_valid;
    rfd_pkg::t_kind     r_kind, n_kind;
    logic [7:0]         r_data, n_data;

    logic               accept;
    logic signed [12:0] first_ext;
    logic signed [12:0] limit;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_data_byte = r_data;

    assign first_ext = {{4{r_first[8]}}, r_first};
    assign limit     = r_decl - $signed({9'd0, rfd_pkg::HEADER_BYTES});

    always_comb begin
        n_phase   = r_phase;
        n_first   = r_first;
        n_decl    = r_decl;
        n_rtype   = r_rtype;
        n_scanned = r_scanned;
        n_escape  = r_escape;
        n_kind    = rfd_pkg::K_NONE;
        n_data    = 8'd0;
        case (r_phase)
            rfd_pkg::PH_HUNT: begin
                if (i_rx_byte == rfd_pkg::CH_START) begin
                    n_phase = rfd_pkg::PH_LEN1;
                end
            end
            rfd_pkg::PH_LEN1: begin
                n_first = $signed({1'b0, i_rx_byte} - {1'b0, rfd_pkg::CH_ZERO});
                n_phase = rfd_pkg::PH_LEN2;
            end
            rfd_pkg::PH_LEN2: begin
                n_decl  = (first_ext <<< 3) + (first_ext <<< 1)
                        + $signed({5'd0, i_rx_byte}) - $signed({5'd0, rfd_pkg::CH_ZERO});
                n_phase = rfd_pkg::PH_SEP1;
            end
            rfd_pkg::PH_SEP1: begin
                n_phase = (i_rx_byte == rfd_pkg::CH_SEP) ? rfd_pkg::PH_TYPE
                                                         : rfd_pkg::PH_HUNT;
            end
            rfd_pkg::PH_TYPE: begin
                n_rtype = i_rx_byte;
                n_phase = rfd_pkg::PH_SEP2;
            end
            rfd_pkg::PH_SEP2: begin
                n_phase = rfd_pkg::PH_HUNT;
                if (i_rx_byte != rfd_pkg::CH_SEP || r_decl > $signed({6'd0, r_max_len})) begin
                    n_kind = rfd_pkg::K_NONE;
                end else if (r_req_type >= rfd_pkg::CH_DATA_LO
                             && r_req_type <= rfd_pkg::CH_DATA_HI) begin
                    if (r_rtype == r_req_type + rfd_pkg::TYPE_OFFSET) begin
                        n_phase   = rfd_pkg::PH_PAYLOAD;
                        n_scanned = 7'd0;
                        n_escape  = 1'b0;
                    end else begin
                        n_kind = rfd_pkg::K_MISMATCH;
                    end
                end else if (r_req_type >= rfd_pkg::CH_KEY_LO
                             && r_req_type <= rfd_pkg::CH_KEY_HI
                             && r_rtype == rfd_pkg::CH_KEYREPLY) begin
                    n_kind = rfd_pkg::K_KEY;
                end else begin
                    n_kind = rfd_pkg::K_MISMATCH;
                end
            end
            rfd_pkg::PH_PAYLOAD: begin
                if ($signed({6'd0, r_scanned}) >= limit) begin
                    n_phase = rfd_pkg::PH_HUNT;
                    n_kind  = rfd_pkg::K_CORRUPT;
                end else if (i_rx_byte == rfd_pkg::CH_END && !r_escape) begin
                    n_phase = rfd_pkg::PH_HUNT;
                    n_kind  = rfd_pkg::K_DONE;
                end else begin
                    n_scanned = r_scanned + 7'd1;
                    if (!r_escape && i_rx_byte == rfd_pkg::CH_ESC) begin
                        n_escape = 1'b1;
                    end else begin
                        if (r_escape && (i_rx_byte == rfd_pkg::CH_END
                                         || i_rx_byte == rfd_pkg::CH_ESC
                                         || i_rx_byte == rfd_pkg::CH_SEP)) begin
                            n_escape = 1'b0;
                        end
                        n_kind = rfd_pkg::K_DATA;
                        n_data = i_rx_byte;
                    end
                end
            end
            default: begin
                n_phase = rfd_pkg::PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= rfd_pkg::PH_HUNT;
            r_first     <= '0;
            r_decl      <= '0;
            r_rtype     <= '0;
            r_scanned   <= '0;
            r_escape    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase     <= n_phase;
                r_first     <= n_first;
                r_decl      <= n_decl;
                r_rtype     <= n_rtype;
                r_scanned   <= n_scanned;
                r_escape    <= n_escape;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= n_kind;
            r_data <= n_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_type <= rfd_pkg::REQ_TYPE_RESET;
            r_max_len  <= rfd_pkg::MAX_LENGTH_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == rfd_pkg::REG_REQUESTED_TYPE) begin
                r_req_type <= i_cfg_data;
            end else if (i_cfg_index == rfd_pkg::REG_MAX_LENGTH) begin
                r_max_len <= i_cfg_data[6:0];
            end
        end
    end

    a_data_only_with_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind != rfd_pkg::K_DATA) |-> (r_data == 8'd0))
        else $error("data byte nonzero on a non-payload result");

    a_hunt_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_phase == rfd_pkg::PH_HUNT)
        |=> (r_phase == rfd_pkg::PH_HUNT || r_phase == rfd_pkg::PH_LEN1))
        else $error("hunting phase left for a state other than the first length digit");

    a_payload_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_phase != rfd_pkg::PH_PAYLOAD && n_phase == rfd_pkg::PH_PAYLOAD)
        |=> (r_scanned == 7'd0 && !r_escape))
        else $error("payload entered with stale scan count or escape");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_kind <= rfd_pkg::K_CORRUPT))
        else $error("result kind out of range");

endmodule
